/* rtl/etc_pkg.sv */
// Shared constants, types and helper functions of the escape-time pixel colouriser.
package etc_pkg;

    localparam int FRAC_BITS = 28;
    localparam logic [10:0] ITER_CAP = 11'd2000;

    // restoring divider geometry
    localparam int DVD_W = 45;
    localparam int DSR_W = 13;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);

    localparam logic signed [63:0] FOUR = 64'sd4 <<< FRAC_BITS;
    localparam logic signed [63:0] SAT_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] SAT_MIN = {1'b1, {63{1'b0}}};

    // register indexes
    localparam logic [2:0] REG_MAX_ITER = 3'd0;
    localparam logic [2:0] REG_MIN_REAL = 3'd1;
    localparam logic [2:0] REG_MAX_REAL = 3'd2;
    localparam logic [2:0] REG_MIN_IMAG = 3'd3;
    localparam logic [2:0] REG_MAX_IMAG = 3'd4;
    localparam logic [2:0] REG_WIDTH    = 3'd5;
    localparam logic [2:0] REG_HEIGHT   = 3'd6;

    // divider operand selection
    localparam logic [1:0] DIV_MAP  = 2'd0;
    localparam logic [1:0] DIV_COLQ = 2'd1;
    localparam logic [1:0] DIV_CHAN = 2'd2;

    typedef struct packed {
        logic [10:0]        max_iter;
        logic signed [31:0] min_r;
        logic signed [31:0] max_r;
        logic signed [31:0] min_i;
        logic signed [31:0] max_i;
        logic [12:0]        width;
        logic [12:0]        height;
    } cfg_t;

    typedef struct packed {
        logic       load;
        logic       map_mul;
        logic       div_start;
        logic [1:0] div_mode;
        logic       map_fin;
        logic       upd1;
        logic       upd2;
        logic       sum;
        logic       sq_start;
        logic       sq_take;
        logic       col_take;
        logic       ch_take;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic sq_done;
        logic cont;
        logic out_free;
    } sts_t;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? SAT_MIN : SAT_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? SAT_MIN : SAT_MAX;
        end
        return s[63:0];
    endfunction

    // palette: black, blue, yellow, green, cyan, red, magenta, white
    function automatic logic [7:0] pal_chan(input logic [2:0] idx, input logic [1:0] ch);
        logic [2:0] rgb;
        unique case (idx)
            3'd0: rgb = 3'b000;
            3'd1: rgb = 3'b001;
            3'd2: rgb = 3'b110;
            3'd3: rgb = 3'b010;
            3'd4: rgb = 3'b011;
            3'd5: rgb = 3'b100;
            3'd6: rgb = 3'b101;
            default: rgb = 3'b111;
        endcase
        unique case (ch)
            2'd0: return rgb[2] ? 8'd255 : 8'd0;
            2'd1: return rgb[1] ? 8'd255 : 8'd0;
            default: return rgb[0] ? 8'd255 : 8'd0;
        endcase
    endfunction

endpackage

/* rtl/etc_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module etc_div import etc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output logic [DSR_W-1:0] remainder,
    output logic             done
);

    logic [DVD_W-1:0]     dvd_reg;
    logic [DSR_W-1:0]     dsr_reg;
    logic [DSR_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;

    logic [DSR_W:0]   rs;
    logic [DSR_W:0]   diff;
    logic             ge;
    logic [DSR_W-1:0] rem_next;

    always_comb begin
        rs       = {rem_reg, dvd_reg[DVD_W-1]};
        diff     = rs - {1'b0, dsr_reg};
        ge       = rs >= {1'b0, dsr_reg};
        rem_next = ge ? diff[DSR_W-1:0] : rs[DSR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= DIV_CNT_W'(DVD_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (cnt_reg != '0) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign quotient  = dvd_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

/* rtl/etc_sqr.sv */
// Saturating fixed-point square built from three 32x32 partial products in turn.
module etc_sqr import etc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] operand,
    output logic signed [63:0] result,
    output logic               done
);

    logic [63:0]        a_reg;
    logic [63:0]        prod_reg;
    logic [127:0]       acc_reg;
    logic [2:0]         ph_reg;
    logic               done_reg;
    logic signed [63:0] res_reg;
    logic [63:0]        mag;

    assign mag = operand[63] ? (64'd0 - operand) : operand;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg   <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                ph_reg <= 3'd1;
            end else if (ph_reg == 3'd5) begin
                ph_reg   <= '0;
                done_reg <= 1'b1;
            end else if (ph_reg != '0) begin
                ph_reg <= ph_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= mag;
        end
        unique case (ph_reg)
            3'd1: prod_reg <= a_reg[31:0] * a_reg[31:0];
            3'd2: begin
                acc_reg  <= {64'd0, prod_reg};
                prod_reg <= a_reg[31:0] * a_reg[63:32];
            end
            3'd3: begin
                // cross term counted twice
                acc_reg  <= acc_reg + {31'd0, prod_reg, 33'd0};
                prod_reg <= a_reg[63:32] * a_reg[63:32];
            end
            3'd4: acc_reg <= acc_reg + {prod_reg, 64'd0};
            3'd5: begin
                if (acc_reg[127:63+FRAC_BITS] != '0) begin
                    res_reg <= SAT_MAX;
                end else begin
                    res_reg <= {1'b0, acc_reg[62+FRAC_BITS:FRAC_BITS]};
                end
            end
            default: ;
        endcase
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule

/* rtl/etc_datapath.sv */
// Datapath: coordinate mapping, escape iteration registers, colour blend and output register.
module etc_datapath import etc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  cfg_t        cfg,
    input  logic [11:0] in_x,
    input  logic [11:0] in_y,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [63:0] m_tdata
);

    logic [11:0]        px_reg, py_reg;
    logic [10:0]        lim_reg, n_reg;
    logic               neg_r_reg, neg_i_reg;
    logic [DVD_W-1:0]   dvd_r_reg, dvd_i_reg;
    logic signed [63:0] cr_reg, ci_reg;
    logic signed [63:0] re_reg, im_reg, s_reg, t_reg;
    logic signed [63:0] re2_reg, im2_reg, w_reg;
    logic [2:0]         q_reg;
    logic [10:0]        f_reg;
    logic [7:0]         red_reg, green_reg, blue_reg;
    logic               m_tvalid_reg;
    logic [63:0]        m_tdata_reg;

    logic [10:0]        lim_c;
    logic [12:0]        width_eff, height_eff;
    logic signed [32:0] span_r, span_i;
    logic signed [45:0] prod_r, prod_i, abs_r, abs_i;
    logic [DVD_W-1:0]   dd0, dd1, dd2;
    logic [DSR_W-1:0]   ds0, ds1, ds2;
    logic [DVD_W-1:0]   quo0, quo1, quo2;
    logic [DSR_W-1:0]   rem0, rem1, rem2;
    logic               dv_done0, dv_done1, dv_done2;
    logic [10:0]        cn;
    logic [13:0]        num7;
    logic [2:0]         k;
    logic [18:0]        chn [3];
    logic signed [63:0] qv_r, qv_i, s_chk;
    logic signed [63:0] sq_re, sq_im, sq_s;
    logic               sq_done0, sq_done1, sq_done2;

    always_comb begin
        if (cfg.max_iter == '0) begin
            lim_c = 11'd1;
        end else if (cfg.max_iter > ITER_CAP) begin
            lim_c = ITER_CAP;
        end else begin
            lim_c = cfg.max_iter;
        end
        width_eff  = (cfg.width == '0) ? 13'd1 : cfg.width;
        height_eff = (cfg.height == '0) ? 13'd1 : cfg.height;
        span_r = {cfg.max_r[31], cfg.max_r} - {cfg.min_r[31], cfg.min_r};
        span_i = {cfg.max_i[31], cfg.max_i} - {cfg.min_i[31], cfg.min_i};
        prod_r = span_r * $signed({1'b0, px_reg});
        prod_i = span_i * $signed({1'b0, py_reg});
        abs_r  = prod_r[45] ? -prod_r : prod_r;
        abs_i  = prod_i[45] ? -prod_i : prod_i;
        qv_r   = {19'd0, quo0};
        qv_i   = {19'd0, quo1};
        cn     = (n_reg == lim_reg) ? 11'd0 : n_reg;
        num7   = {3'd0, cn} * 14'd7;
        k      = (q_reg == 3'd7) ? 3'd7 : q_reg + 3'd1;
        for (int c = 0; c < 3; c++) begin
            chn[c] = pal_chan(q_reg, 2'(c)) * (lim_reg - f_reg)
                   + pal_chan(k, 2'(c)) * f_reg;
        end
        s_chk = sat_add(re2_reg, im2_reg);
    end

    always_comb begin
        dd0 = '0; dd1 = '0; dd2 = '0;
        ds0 = {2'd0, lim_reg}; ds1 = {2'd0, lim_reg}; ds2 = {2'd0, lim_reg};
        unique case (cmd.div_mode)
            DIV_MAP: begin
                dd0 = dvd_r_reg; ds0 = width_eff;
                dd1 = dvd_i_reg; ds1 = height_eff;
            end
            DIV_COLQ: dd0 = {31'd0, num7};
            DIV_CHAN: begin
                dd0 = {26'd0, chn[0]};
                dd1 = {26'd0, chn[1]};
                dd2 = {26'd0, chn[2]};
            end
            default: ;
        endcase
    end

    etc_div u_div0 (.aclk, .aresetn, .start(cmd.div_start), .dividend(dd0), .divisor(ds0),
                    .quotient(quo0), .remainder(rem0), .done(dv_done0));
    etc_div u_div1 (.aclk, .aresetn, .start(cmd.div_start), .dividend(dd1), .divisor(ds1),
                    .quotient(quo1), .remainder(rem1), .done(dv_done1));
    etc_div u_div2 (.aclk, .aresetn, .start(cmd.div_start), .dividend(dd2), .divisor(ds2),
                    .quotient(quo2), .remainder(rem2), .done(dv_done2));

    etc_sqr u_sq_re (.aclk, .aresetn, .start(cmd.sq_start), .operand(re_reg),
                     .result(sq_re), .done(sq_done0));
    etc_sqr u_sq_im (.aclk, .aresetn, .start(cmd.sq_start), .operand(im_reg),
                     .result(sq_im), .done(sq_done1));
    etc_sqr u_sq_s  (.aclk, .aresetn, .start(cmd.sq_start), .operand(s_reg),
                     .result(sq_s), .done(sq_done2));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            px_reg  <= in_x;
            py_reg  <= in_y;
            lim_reg <= lim_c;
            n_reg   <= '0;
            re2_reg <= '0;
            im2_reg <= '0;
            w_reg   <= '0;
        end
        if (cmd.map_mul) begin
            neg_r_reg <= prod_r[45];
            neg_i_reg <= prod_i[45];
            dvd_r_reg <= abs_r[DVD_W-1:0];
            dvd_i_reg <= abs_i[DVD_W-1:0];
        end
        if (cmd.map_fin) begin
            cr_reg <= {{32{cfg.min_r[31]}}, cfg.min_r} + (neg_r_reg ? -qv_r : qv_r);
            ci_reg <= {{32{cfg.min_i[31]}}, cfg.min_i} + (neg_i_reg ? -qv_i : qv_i);
        end
        if (cmd.upd1) begin
            re_reg <= sat_add(sat_sub(re2_reg, im2_reg), cr_reg);
            t_reg  <= sat_sub(w_reg, re2_reg);
            n_reg  <= n_reg + 11'd1;
        end
        if (cmd.upd2) begin
            im_reg <= sat_add(sat_sub(t_reg, im2_reg), ci_reg);
        end
        if (cmd.sum) begin
            s_reg <= sat_add(re_reg, im_reg);
        end
        if (cmd.sq_take) begin
            re2_reg <= sq_re;
            im2_reg <= sq_im;
            w_reg   <= sq_s;
        end
        if (cmd.col_take) begin
            q_reg <= quo0[2:0];
            f_reg <= rem0[10:0];
        end
        if (cmd.ch_take) begin
            red_reg   <= quo0[7:0];
            green_reg <= quo1[7:0];
            blue_reg  <= quo2[7:0];
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {5'd0, blue_reg, green_reg, red_reg, n_reg, py_reg, px_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign sts.div_done = dv_done0 & dv_done1 & dv_done2;
    assign sts.sq_done  = sq_done0 & sq_done1 & sq_done2;
    assign sts.cont     = (s_chk <= FOUR) && (s_chk != SAT_MAX) && (n_reg < lim_reg);
    assign sts.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* rtl/etc_ctrl.sv */
// Controller state machine sequencing mapping, iteration and colour blend.
module etc_ctrl import etc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_MAP_MUL  = 4'd1;
    localparam logic [3:0] ST_MAP_DIV  = 4'd2;
    localparam logic [3:0] ST_MAP_WAIT = 4'd3;
    localparam logic [3:0] ST_MAP_FIN  = 4'd4;
    localparam logic [3:0] ST_CHECK    = 4'd5;
    localparam logic [3:0] ST_UPD1     = 4'd6;
    localparam logic [3:0] ST_UPD2     = 4'd7;
    localparam logic [3:0] ST_SUM      = 4'd8;
    localparam logic [3:0] ST_SQ       = 4'd9;
    localparam logic [3:0] ST_SQ_WAIT  = 4'd10;
    localparam logic [3:0] ST_COL_DIV  = 4'd11;
    localparam logic [3:0] ST_COL_WAIT = 4'd12;
    localparam logic [3:0] ST_CH_DIV   = 4'd13;
    localparam logic [3:0] ST_CH_WAIT  = 4'd14;
    localparam logic [3:0] ST_OUT      = 4'd15;

    logic [3:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MAP_MUL;
                end
            end
            ST_MAP_MUL: begin
                cmd.map_mul = 1'b1;
                state_next  = ST_MAP_DIV;
            end
            ST_MAP_DIV: begin
                cmd.div_start = 1'b1;
                cmd.div_mode  = DIV_MAP;
                state_next    = ST_MAP_WAIT;
            end
            ST_MAP_WAIT: begin
                if (sts.div_done) begin
                    state_next = ST_MAP_FIN;
                end
            end
            ST_MAP_FIN: begin
                cmd.map_fin = 1'b1;
                state_next  = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = sts.cont ? ST_UPD1 : ST_COL_DIV;
            end
            ST_UPD1: begin
                cmd.upd1   = 1'b1;
                state_next = ST_UPD2;
            end
            ST_UPD2: begin
                cmd.upd2   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                cmd.sq_start = 1'b1;
                state_next   = ST_SQ_WAIT;
            end
            ST_SQ_WAIT: begin
                if (sts.sq_done) begin
                    cmd.sq_take = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_COL_DIV: begin
                cmd.div_start = 1'b1;
                cmd.div_mode  = DIV_COLQ;
                state_next    = ST_COL_WAIT;
            end
            ST_COL_WAIT: begin
                if (sts.div_done) begin
                    cmd.col_take = 1'b1;
                    state_next   = ST_CH_DIV;
                end
            end
            ST_CH_DIV: begin
                cmd.div_start = 1'b1;
                cmd.div_mode  = DIV_CHAN;
                state_next    = ST_CH_WAIT;
            end
            ST_CH_WAIT: begin
                if (sts.div_done) begin
                    cmd.ch_take = 1'b1;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

/* rtl/escape_time_pixel_colorizer.sv */
// Top level: register file, controller and datapath of the escape-time pixel colouriser.
//
// Usage:
//   Slave stream (s_*): one beat per pixel, tdata carries the column and row.
//   Master stream (m_*): one beat per pixel with the echoed coordinates, the
//   escape count and the blended RGB colour.
//   APB port: seven registers at byte addresses 0, 4, ... 24 (iteration limit,
//   window edges in Q4.28, image width and height); write only while idle.
// Timing:
//   One pixel is processed at a time. Mapping uses one 45-step restoring
//   divide, each escape iteration three squarers (each forming three 32x32
//   partial products in turn), and the colour blend two 45-step divides.
// Reset:
//   aresetn is synchronous, active low; it restores the register defaults and
//   empties the output register.
// Stall:
//   The result sits in an output register; a new pixel is accepted while it
//   waits, and the block holds in its final step until that register is free.
module escape_time_pixel_colorizer import etc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // pixel in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // [11:0] pixel_x, [23:12] pixel_y
    // colour out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata   // [11:0] out_x, [23:12] out_y, [34:24] escape_count,
                                  // [42:35] red, [50:43] green, [58:51] blue
);

    cfg_t       cfg_reg;
    cmd_t       cmd;
    sts_t       sts;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    // register file; writes land in the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_iter <= 11'd256;
            cfg_reg.min_r    <= 32'shE0000000;   // -2.0
            cfg_reg.max_r    <= 32'sh10000000;   //  1.0
            cfg_reg.min_i    <= 32'shF0000000;   // -1.0
            cfg_reg.max_i    <= 32'sh10000000;   //  1.0
            cfg_reg.width    <= 13'd800;
            cfg_reg.height   <= 13'd600;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MAX_ITER: cfg_reg.max_iter <= pwdata[10:0];
                REG_MIN_REAL: cfg_reg.min_r    <= pwdata;
                REG_MAX_REAL: cfg_reg.max_r    <= pwdata;
                REG_MIN_IMAG: cfg_reg.min_i    <= pwdata;
                REG_MAX_IMAG: cfg_reg.max_i    <= pwdata;
                REG_WIDTH:    cfg_reg.width    <= pwdata[12:0];
                REG_HEIGHT:   cfg_reg.height   <= pwdata[12:0];
                default: ;    // unmapped address: ignored
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MAX_ITER: prdata = {21'd0, cfg_reg.max_iter};
            REG_MIN_REAL: prdata = cfg_reg.min_r;
            REG_MAX_REAL: prdata = cfg_reg.max_r;
            REG_MIN_IMAG: prdata = cfg_reg.min_i;
            REG_MAX_IMAG: prdata = cfg_reg.max_i;
            REG_WIDTH:    prdata = {19'd0, cfg_reg.width};
            REG_HEIGHT:   prdata = {19'd0, cfg_reg.height};
            default:      prdata = '0;
        endcase
    end

    etc_ctrl u_ctrl (
        .aclk,
        .aresetn,
        .s_tvalid,
        .s_tready,
        .sts,
        .cmd
    );

    etc_datapath u_dp (
        .aclk,
        .aresetn,
        .cmd,
        .sts,
        .cfg      (cfg_reg),
        .in_x     (s_tdata[11:0]),
        .in_y     (s_tdata[23:12]),
        .m_tready,
        .m_tvalid,
        .m_tdata
    );

endmodule
